FILE: rtl/core/bpsg_pkg.sv
// Shared types, constants and the control-store contents for the balance controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bpsg_pkg;

	// fixed-point formats
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int SPEED_FRAC_BITS = 8;
	localparam int RAD_TO_DEG_Q16  = 3754937;
	localparam int GAIN_ROUND      = (1 << GAIN_FRAC_BITS) - 1;

	// 1000 = 125 * 2^3: the odd factor goes through the divider, the rest is a shift
	localparam int INT_SHIFT = 3 + GAIN_FRAC_BITS;
	localparam int SPD_SHIFT = 3 + 16 + ANGLE_FRAC_BITS - SPEED_FRAC_BITS;

	// datapath widths
	localparam int PROD_W = 63;
	localparam int ACC_W  = 45;
	localparam int SUM_W  = 50;

	// divide-by-125 unit
	localparam int DIV_W          = 48;
	localparam int DIV_RADIX_BITS = 8;
	localparam int DIV_ITERS      = DIV_W / DIV_RADIX_BITS;
	localparam int DIV_REM_W      = 7;
	localparam int DIV_CNT_W      = $clog2(DIV_ITERS);
	localparam logic [DIV_REM_W:0] DIV_K = 8'd125;

	// configuration port
	localparam int ADDR_W = 5;
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_PROP_GAIN   = 3'd0;
	localparam reg_idx_t REG_INT_GAIN    = 3'd1;
	localparam reg_idx_t REG_DERIV_GAIN  = 3'd2;
	localparam reg_idx_t REG_ENTER_LIMIT = 3'd3;
	localparam reg_idx_t REG_EXIT_LIMIT  = 3'd4;
	localparam reg_idx_t REG_GUARD_ANGLE = 3'd5;
	localparam reg_idx_t REG_SPEED_CLAMP = 3'd6;

	localparam logic signed [31:0] PROP_GAIN_RST   = -32'sd1100800;
	localparam logic signed [31:0] INT_GAIN_RST    = 32'sd0;
	localparam logic signed [31:0] DERIV_GAIN_RST  = -32'sd81920;
	localparam logic [14:0]        ENTER_LIMIT_RST = 15'd32767;
	localparam logic [14:0]        EXIT_LIMIT_RST  = 15'd0;
	localparam logic [14:0]        GUARD_ANGLE_RST = 15'd0;
	localparam logic [22:0]        SPEED_CLAMP_RST = 23'd8388607;

	typedef struct packed {
		logic               command;
		logic signed [15:0] tilt_angle;
		logic signed [19:0] tilt_rate;
		logic signed [15:0] wheel_speed;
		logic [7:0]         elapsed_ms;
	} sample_t;

	typedef struct packed {
		logic signed [23:0] speed_setpoint;
		logic signed [15:0] angle_setpoint;
		logic               guard_active;
		logic signed [31:0] accel_demand;
	} result_t;

	typedef struct packed {
		logic signed [31:0] prop_gain;
		logic signed [31:0] integral_gain;
		logic signed [31:0] deriv_gain;
		logic [14:0]        speed_enter_limit;
		logic [14:0]        speed_exit_limit;
		logic [14:0]        guard_angle;
		logic [22:0]        speed_clamp;
	} cfg_t;

	// datapath operations, one per control word
	typedef enum logic [4:0] {
		OP_NOP,
		OP_GUARD,
		OP_ERR,
		OP_MUL_EMS,
		OP_MUL_KI,
		OP_LOAD_INT,
		OP_DIV,
		OP_ISUM,
		OP_MUL_KP,
		OP_PTERM,
		OP_MUL_KD,
		OP_DTERM,
		OP_SAT,
		OP_MUL_RM,
		OP_MUL_AR,
		OP_LOAD_SPD,
		OP_SPD,
		OP_EMIT
	} op_t;

	// sequencing of the step counter
	typedef enum logic [2:0] {
		SQ_NEXT,
		SQ_WAIT_IN,
		SQ_BR_RESTART,
		SQ_LOOP_DIV,
		SQ_WAIT_OUT
	} seq_t;

	typedef logic [4:0] step_t;
	localparam step_t ST_FETCH    = 5'd0;
	localparam step_t ST_GUARD    = 5'd1;
	localparam step_t ST_ERR      = 5'd2;
	localparam step_t ST_MUL_EMS  = 5'd3;
	localparam step_t ST_MUL_KI   = 5'd4;
	localparam step_t ST_LOAD_INT = 5'd5;
	localparam step_t ST_DIV_INT  = 5'd6;
	localparam step_t ST_ISUM     = 5'd7;
	localparam step_t ST_MUL_KP   = 5'd8;
	localparam step_t ST_PTERM    = 5'd9;
	localparam step_t ST_MUL_KD   = 5'd10;
	localparam step_t ST_DTERM    = 5'd11;
	localparam step_t ST_SAT      = 5'd12;
	localparam step_t ST_MUL_RM   = 5'd13;
	localparam step_t ST_MUL_AR   = 5'd14;
	localparam step_t ST_LOAD_SPD = 5'd15;
	localparam step_t ST_DIV_SPD  = 5'd16;
	localparam step_t ST_SPD      = 5'd17;
	localparam step_t ST_EMIT     = 5'd18;

	typedef struct packed {
		op_t   op;
		seq_t  seq;
		step_t target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic take;
		logic emit;
	} ctl_t;

	typedef struct packed {
		logic restart;
		logic div_last;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	// control store
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{op: OP_NOP, seq: SQ_NEXT, target: ST_FETCH};
		unique case (s)
			ST_FETCH:    w = '{op: OP_NOP,      seq: SQ_WAIT_IN,    target: ST_FETCH};
			ST_GUARD:    w = '{op: OP_GUARD,    seq: SQ_BR_RESTART, target: ST_EMIT};
			ST_ERR:      w = '{op: OP_ERR,      seq: SQ_NEXT,       target: ST_FETCH};
			ST_MUL_EMS:  w = '{op: OP_MUL_EMS,  seq: SQ_NEXT,       target: ST_FETCH};
			ST_MUL_KI:   w = '{op: OP_MUL_KI,   seq: SQ_NEXT,       target: ST_FETCH};
			ST_LOAD_INT: w = '{op: OP_LOAD_INT, seq: SQ_NEXT,       target: ST_FETCH};
			ST_DIV_INT:  w = '{op: OP_DIV,      seq: SQ_LOOP_DIV,   target: ST_FETCH};
			ST_ISUM:     w = '{op: OP_ISUM,     seq: SQ_NEXT,       target: ST_FETCH};
			ST_MUL_KP:   w = '{op: OP_MUL_KP,   seq: SQ_NEXT,       target: ST_FETCH};
			ST_PTERM:    w = '{op: OP_PTERM,    seq: SQ_NEXT,       target: ST_FETCH};
			ST_MUL_KD:   w = '{op: OP_MUL_KD,   seq: SQ_NEXT,       target: ST_FETCH};
			ST_DTERM:    w = '{op: OP_DTERM,    seq: SQ_NEXT,       target: ST_FETCH};
			ST_SAT:      w = '{op: OP_SAT,      seq: SQ_NEXT,       target: ST_FETCH};
			ST_MUL_RM:   w = '{op: OP_MUL_RM,   seq: SQ_NEXT,       target: ST_FETCH};
			ST_MUL_AR:   w = '{op: OP_MUL_AR,   seq: SQ_NEXT,       target: ST_FETCH};
			ST_LOAD_SPD: w = '{op: OP_LOAD_SPD, seq: SQ_NEXT,       target: ST_FETCH};
			ST_DIV_SPD:  w = '{op: OP_DIV,      seq: SQ_LOOP_DIV,   target: ST_FETCH};
			ST_SPD:      w = '{op: OP_SPD,      seq: SQ_NEXT,       target: ST_FETCH};
			ST_EMIT:     w = '{op: OP_EMIT,     seq: SQ_WAIT_OUT,   target: ST_FETCH};
			default:     w = '{op: OP_NOP,      seq: SQ_NEXT,       target: ST_FETCH};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/core/bpsg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on bpsg_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module bpsg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpsg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output bpsg_pkg::cfg_t              cfg
);
	import bpsg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain         <= PROP_GAIN_RST;
			cfg_q.integral_gain     <= INT_GAIN_RST;
			cfg_q.deriv_gain        <= DERIV_GAIN_RST;
			cfg_q.speed_enter_limit <= ENTER_LIMIT_RST;
			cfg_q.speed_exit_limit  <= EXIT_LIMIT_RST;
			cfg_q.guard_angle       <= GUARD_ANGLE_RST;
			cfg_q.speed_clamp       <= SPEED_CLAMP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_PROP_GAIN:   cfg_q.prop_gain         <= $signed(pwdata);
				REG_INT_GAIN:    cfg_q.integral_gain     <= $signed(pwdata);
				REG_DERIV_GAIN:  cfg_q.deriv_gain        <= $signed(pwdata);
				REG_ENTER_LIMIT: cfg_q.speed_enter_limit <= pwdata[14:0];
				REG_EXIT_LIMIT:  cfg_q.speed_exit_limit  <= pwdata[14:0];
				REG_GUARD_ANGLE: cfg_q.guard_angle       <= pwdata[14:0];
				REG_SPEED_CLAMP: cfg_q.speed_clamp       <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:   prdata = cfg_q.prop_gain;
			REG_INT_GAIN:    prdata = cfg_q.integral_gain;
			REG_DERIV_GAIN:  prdata = cfg_q.deriv_gain;
			REG_ENTER_LIMIT: prdata = {17'd0, cfg_q.speed_enter_limit};
			REG_EXIT_LIMIT:  prdata = {17'd0, cfg_q.speed_exit_limit};
			REG_GUARD_ANGLE: prdata = {17'd0, cfg_q.guard_angle};
			REG_SPEED_CLAMP: prdata = {9'd0, cfg_q.speed_clamp};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/core/bpsg_div.sv
// Divide-by-125 unit: restoring division, eight quotient bits per step.
// Depends on bpsg_pkg for widths and div_ctl_t.
`timescale 1ns / 1ps

module bpsg_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bpsg_pkg::div_ctl_t         ctl,
	input  logic [bpsg_pkg::DIV_W-1:0] dividend,
	output logic [bpsg_pkg::DIV_W-1:0] quotient,
	output logic                       last
);
	import bpsg_pkg::*;

	logic [DIV_W-1:0]     q_q;
	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     q_nxt;
	logic [DIV_REM_W-1:0] rem_nxt;

	// dividend shifts out the top while quotient bits shift in below
	always_comb begin
		logic [DIV_REM_W:0] trial;
		q_nxt   = q_q;
		rem_nxt = rem_q;
		for (int i = 0; i < DIV_RADIX_BITS; i++) begin
			trial = {rem_nxt, q_nxt[DIV_W-1]};
			q_nxt = {q_nxt[DIV_W-2:0], 1'b0};
			if (trial >= DIV_K) begin
				rem_nxt  = DIV_REM_W'(trial - DIV_K);
				q_nxt[0] = 1'b1;
			end else begin
				rem_nxt = trial[DIV_REM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= DIV_CNT_W'(cnt_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			q_q   <= dividend;
			rem_q <= '0;
		end else if (ctl.step) begin
			q_q   <= q_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign quotient = q_q;
	assign last     = (cnt_q == DIV_CNT_W'(DIV_ITERS - 1));

endmodule

FILE: rtl/core/bpsg_datapath.sv
// Datapath: speed guard, shared multiplier, PID accumulation, speed target and result register.
// Depends on bpsg_pkg and bpsg_div.
`timescale 1ns / 1ps

module bpsg_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bpsg_pkg::cfg_t      cfg,
	input  bpsg_pkg::ctl_t      ctl,
	output bpsg_pkg::status_t   status,
	input  bpsg_pkg::sample_t   sample,
	output logic                result_valid,
	input  logic                result_ready,
	output bpsg_pkg::result_t   result
);
	import bpsg_pkg::*;

	sample_t                   item_q;
	logic                      guard_q;
	logic signed [15:0]        atgt_q;
	logic signed [16:0]        err_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      neg_q;
	logic signed [31:0]        isum_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [31:0]        accel_q;
	logic signed [23:0]        spd_q;
	result_t                   result_q;
	logic                      result_valid_q;

	logic                      guard_nxt;
	logic signed [15:0]        atgt_nxt;
	logic signed [31:0]        mul_a;
	logic signed [30:0]        mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic                      mul_en;
	logic [PROD_W-1:0]         prod_mag;
	logic [DIV_W-1:0]          div_in;
	logic [DIV_W-1:0]          div_q;
	logic                      div_last;
	div_ctl_t                  div_ctl;
	logic signed [PROD_W-1:0]  prod_bias;
	logic signed [PROD_W-1:0]  prod_scaled;
	logic signed [ACC_W-1:0]   gterm;
	logic signed [SUM_W-1:0]   qterm;
	logic signed [SUM_W-1:0]   isum_sum;
	logic signed [SUM_W-1:0]   spd_sum;
	logic signed [SUM_W-1:0]   spd_lim;
	logic signed [23:0]        spd_nxt;
	logic                      out_free;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
		if (x[SUM_W-1:31] == {(SUM_W - 31){x[31]}})
			return x[31:0];
		else if (x[SUM_W-1])
			return 32'sh8000_0000;
		else
			return 32'sh7FFF_FFFF;
	endfunction

	// speed guard with hysteresis; exit test runs after entry
	always_comb begin
		logic signed [16:0] wheel;
		logic signed [16:0] enter;
		logic signed [16:0] mag;
		wheel     = 17'(item_q.wheel_speed);
		enter     = $signed({2'b00, cfg.speed_enter_limit});
		mag       = wheel[16] ? -wheel : wheel;
		guard_nxt = guard_q;
		atgt_nxt  = atgt_q;
		if (!guard_q && wheel > enter) begin
			guard_nxt = 1'b1;
			atgt_nxt  = -$signed({1'b0, cfg.guard_angle});
		end else if (!guard_q && wheel < -enter) begin
			guard_nxt = 1'b1;
			atgt_nxt  = $signed({1'b0, cfg.guard_angle});
		end else if (!guard_q) begin
			atgt_nxt = '0;
		end
		if (guard_nxt && mag < $signed({2'b00, cfg.speed_exit_limit})) begin
			guard_nxt = 1'b0;
			atgt_nxt  = '0;
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (ctl.op)
			OP_MUL_EMS: begin
				mul_a = 32'(err_q);
				mul_b = $signed({23'd0, item_q.elapsed_ms});
			end
			OP_MUL_KI: begin
				mul_a = cfg.integral_gain;
				mul_b = $signed(prod_q[30:0]);
			end
			OP_MUL_KP: begin
				mul_a = cfg.prop_gain;
				mul_b = 31'(err_q);
			end
			OP_MUL_KD: begin
				mul_a = cfg.deriv_gain;
				mul_b = 31'(item_q.tilt_rate);
			end
			OP_MUL_RM: begin
				mul_a = 32'(RAD_TO_DEG_Q16);
				mul_b = $signed({23'd0, item_q.elapsed_ms});
			end
			OP_MUL_AR: begin
				mul_a = accel_q;
				mul_b = $signed(prod_q[30:0]);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// gain products: divide by 2^GAIN_FRAC_BITS, toward zero
	assign prod_bias   = prod_q + (prod_q[PROD_W-1] ? PROD_W'(GAIN_ROUND) : PROD_W'(0));
	assign prod_scaled = prod_bias >>> GAIN_FRAC_BITS;
	assign gterm       = prod_scaled[ACC_W-1:0];

	// magnitude feeds the divider, sign is reapplied afterwards
	assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign div_in   = (ctl.op == OP_LOAD_INT) ? DIV_W'(prod_mag >> INT_SHIFT)
	                                          : DIV_W'(prod_mag >> SPD_SHIFT);
	assign div_ctl.load = (ctl.op == OP_LOAD_INT) || (ctl.op == OP_LOAD_SPD);
	assign div_ctl.step = (ctl.op == OP_DIV);

	bpsg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_in),
		.quotient (div_q),
		.last     (div_last)
	);

	assign qterm    = neg_q ? -SUM_W'($signed({1'b0, div_q})) : SUM_W'($signed({1'b0, div_q}));
	assign isum_sum = SUM_W'(isum_q) + qterm;
	assign spd_sum  = SUM_W'(spd_q) + qterm;
	assign spd_lim  = SUM_W'($signed({1'b0, cfg.speed_clamp}));

	always_comb begin
		if (spd_sum > spd_lim)
			spd_nxt = spd_lim[23:0];
		else if (spd_sum < -spd_lim)
			spd_nxt = 24'(-spd_lim);
		else
			spd_nxt = spd_sum[23:0];
	end

	assign out_free = !result_valid_q || result_ready;

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_q        <= 1'b0;
			atgt_q         <= '0;
			isum_q         <= '0;
			spd_q          <= '0;
			accel_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_GUARD: begin
					if (item_q.command) begin
						guard_q <= 1'b0;
						atgt_q  <= '0;
						isum_q  <= '0;
						spd_q   <= '0;
						accel_q <= '0;
					end else begin
						guard_q <= guard_nxt;
						atgt_q  <= atgt_nxt;
					end
				end
				OP_ISUM: isum_q  <= sat32(isum_sum);
				OP_SAT:  accel_q <= sat32(SUM_W'(acc_q));
				OP_SPD:  spd_q   <= spd_nxt;
				default: ;
			endcase
			if (ctl.emit)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.take)
			item_q <= sample;
		if (mul_en)
			prod_q <= mul_p;
		if (div_ctl.load)
			neg_q <= prod_q[PROD_W-1];
		unique case (ctl.op)
			OP_ERR:   err_q <= 17'(atgt_q) - 17'(item_q.tilt_angle);
			OP_PTERM: acc_q <= gterm + ACC_W'(isum_q);
			OP_DTERM: acc_q <= acc_q - gterm;
			default: ;
		endcase
		if (ctl.emit) begin
			result_q.speed_setpoint <= spd_q;
			result_q.angle_setpoint <= atgt_q;
			result_q.guard_active   <= guard_q;
			result_q.accel_demand   <= accel_q;
		end
	end

	assign status.restart  = item_q.command;
	assign status.div_last = div_last;
	assign status.out_free = out_free;
	assign result_valid    = result_valid_q;
	assign result          = result_q;

	a_guard_target: assert property (@(posedge clk) disable iff (!arst_n)
		!guard_q |-> atgt_q == 16'sd0)
		else $error("angle target nonzero while guard is off");

	a_speed_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == OP_SPD |=>
			(spd_q <= $signed({1'b0, $past(cfg.speed_clamp)})) &&
			(spd_q >= -$signed({1'b0, $past(cfg.speed_clamp)})))
		else $error("speed target outside clamp");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_GUARD && item_q.command) |=>
			(!guard_q && isum_q == 32'sd0 && spd_q == 24'sd0 && accel_q == 32'sd0))
		else $error("restart left state behind");

endmodule

FILE: rtl/core/bpsg_useq.sv
// Microcode sequencer: step counter, control-store lookup and branch logic.
// Depends on bpsg_pkg for the control store and control/status structs.
`timescale 1ns / 1ps

module bpsg_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  bpsg_pkg::status_t status,
	output bpsg_pkg::ctl_t    ctl
);
	import bpsg_pkg::*;

	step_t  step_q;
	step_t  step_nxt;
	step_t  step_inc;
	uword_t cw;

	assign cw       = ucode(step_q);
	assign step_inc = step_t'(step_q + 1'b1);

	assign sample_ready = (step_q == ST_FETCH);
	assign ctl.op       = cw.op;
	assign ctl.take     = sample_valid && sample_ready;
	assign ctl.emit     = (cw.seq == SQ_WAIT_OUT) && status.out_free;

	always_comb begin
		unique case (cw.seq)
			SQ_NEXT:       step_nxt = step_inc;
			SQ_WAIT_IN:    step_nxt = sample_valid ? step_inc : step_q;
			SQ_BR_RESTART: step_nxt = status.restart ? cw.target : step_inc;
			SQ_LOOP_DIV:   step_nxt = status.div_last ? step_inc : step_q;
			SQ_WAIT_OUT:   step_nxt = status.out_free ? cw.target : step_q;
			default:       step_nxt = ST_FETCH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= ST_FETCH;
		else
			step_q <= step_nxt;
	end

endmodule

FILE: rtl/core/balance_pid_with_speed_guard.sv
// Balance controller: PID on tilt angle with a hysteresis speed guard and speed target.
// Top level; depends on bpsg_pkg, bpsg_regs, bpsg_useq, bpsg_datapath (with bpsg_div).
//
// Usage
//   sample channel (sample_valid/sample_ready/sample): one item per control tick.
//   command 0 runs a compute step, command 1 clears the controller state.
//   result channel (result_valid/result_ready/result): one result item per sample item.
//   APB port: seven 32-bit registers at 4*i, write whenever no item is in flight.
// Sequencing
//   A compute item runs through 17 microcode steps, fetch included, and the two
//   divide loops, which step the divider until it flags its last step; the six
//   products share the single 32x31 multiplier. The next item is accepted only
//   when the sequencer is back on the fetch step. The result is registered on
//   the emit step. A restart item goes from the fetch step through the guard step
//   straight to the emit step.
// Reset
//   arst_n clears the state (guard, target, integral, speed target), loads the
//   register reset values and parks the sequencer on the fetch step.
// Back-pressure
//   The result sits in an output register. While it waits, the next item is accepted
//   and computed; the sequencer holds on its emit step until the slot is free.
`timescale 1ns / 1ps

module balance_pid_with_speed_guard (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpsg_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// sample items
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  bpsg_pkg::sample_t           sample,
	// result items
	output logic                        result_valid,
	input  logic                        result_ready,
	output bpsg_pkg::result_t           result
);
	import bpsg_pkg::*;

	cfg_t    cfg;
	ctl_t    ctl;
	status_t status;

	// register file
	bpsg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step counter and control store; owns the sample handshake
	bpsg_useq u_useq (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.status       (status),
		.ctl          (ctl)
	);

	// guard, multiplier, divider, accumulators and the output register
	bpsg_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.ctl          (ctl),
		.status       (status),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
